@@ rtl/signed_int_to_decimal_ascii_core_assert.svh @@
// Assertion macros shared by the signed integer to decimal text core.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SITOA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define SITOA_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

@@ rtl/sitoa_pkg.sv @@
// Shared widths, character codes and control types for the decimal text core.
package sitoa_pkg;

  localparam int MAG_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = $clog2(MAG_W);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [BCD_W-1:0] bcd_t;

  // Control from the sequencer to the converter.
  typedef struct packed {
    logic start;
  } dab_ctl_t;

  // Status from the converter back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } dab_sts_t;

endpackage

@@ rtl/signed_int_to_decimal_ascii_core.sv @@
// Signed 32-bit integer to decimal ASCII text, one character per output request.
//
// Each input request carries one two's complement value; the core answers with
// its decimal text, most significant character first: '-' for a negative value,
// then the digits without leading zeros ('0' alone for zero), out_last high on
// the final character. The magnitude goes through a bit-serial shift-and-add-3
// BCD converter, then up to 9 leading zero digits are dropped at one per cycle,
// then characters leave at one per cycle when the output side is ready. The
// pace is set by the serial converter and the single output register. The next
// value can be taken in the cycle after the last character has been loaded into
// the output register, while that character may still wait.
`include "signed_int_to_decimal_ascii_core_assert.svh"

module signed_int_to_decimal_ascii_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_character,
  output logic               out_last
);
  import sitoa_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic             neg_r;
  logic             neg_nxt;
  logic [BCD_W-1:0] dig_r;
  logic [BCD_W-1:0] dig_nxt;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [7:0]       out_char_r;
  logic [7:0]       out_char_nxt;
  logic             out_last_r;
  logic             out_last_nxt;

  logic             accept;
  logic             slot_free;
  logic [MAG_W-1:0] in_bits;
  mag_t             mag;
  bcd_t             bcd;
  dab_ctl_t         dab_ctl;
  dab_sts_t         dab_sts;
  logic [3:0]       top_digit;
  logic             emit_rem_ok;
  logic             last_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign top_digit = dig_r[BCD_W-1 -: 4];

  // Magnitude at full unsigned width, so the most negative value is exact.
  assign in_bits = $unsigned(in_value);
  assign mag     = in_bits[MAG_W-1] ? (MAG_W'(0) - in_bits) : in_bits;

  assign dab_ctl.start = accept;

  sitoa_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (dab_ctl),
    .mag_i (mag),
    .sts_o (dab_sts),
    .bcd_o (bcd)
  );

  // Sequencer: convert, drop leading zeros, then send sign and digits.
  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    dig_nxt       = dig_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt   = in_bits[MAG_W-1];
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (dab_sts.done) begin
          dig_nxt   = bcd;
          rem_nxt   = REM_W'(NUM_DIGITS);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && rem_r > REM_W'(1)) begin
          dig_nxt = {dig_r[BCD_W-5:0], 4'd0};
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {4'd0, top_digit};
          out_last_nxt  = (rem_r == REM_W'(1));
          dig_nxt       = {dig_r[BCD_W-5:0], 4'd0};
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    dig_r      <= dig_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // Terms watched by the checks below.
  assign emit_rem_ok = (rem_r != '0) && (rem_r <= REM_W'(NUM_DIGITS));
  assign last_load   = (state_r == ST_EMIT) && slot_free && (rem_r == REM_W'(1));

  // A new request is only taken while the converter is free.
  `SITOA_ASSERT_ALWAYS(a_ready_conv_idle, !(in_ready && dab_sts.busy), "request taken while converting")
  // The converter finishes only while the sequencer waits for it.
  `SITOA_ASSERT_ALWAYS(a_done_in_conv, !dab_sts.done || state_r == ST_CONV, "conversion done out of turn")
  // Emitting a digit always has at least one digit left.
  `SITOA_ASSERT_ALWAYS(a_emit_count, state_r != ST_EMIT || emit_rem_ok, "digit count out of range")
  // After the last character is loaded the sequencer is idle.
  `SITOA_ASSERT_NEXT(a_last_idle, last_load, state_r == ST_IDLE && out_last_r, "last character mismatch")

endmodule

@@ rtl/sitoa_dabble.sv @@
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module sitoa_dabble (
  input  logic                clk,
  input  logic                rst_n,
  input  sitoa_pkg::dab_ctl_t ctl_i,
  input  sitoa_pkg::mag_t     mag_i,
  output sitoa_pkg::dab_sts_t sts_o,
  output sitoa_pkg::bcd_t     bcd_o
);
  import sitoa_pkg::*;

  logic [MAG_W-1:0]     bin_r;
  logic [MAG_W-1:0]     bin_nxt;
  logic [BCD_W-1:0]     bcd_r;
  logic [BCD_W-1:0]     bcd_nxt;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] cnt_r;
  logic [BIT_CNT_W-1:0] cnt_nxt;
  logic                 busy_r;
  logic                 busy_nxt;
  logic                 done_r;
  logic                 done_nxt;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Load on start, otherwise while busy shift one binary bit into the BCD word per cycle.
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl_i.start) begin
      bin_nxt  = mag_i;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bin_nxt = {bin_r[MAG_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[MAG_W-1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BIT_CNT_W'(MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;
  assign bcd_o      = bcd_r;

endmodule

@@ bench/signed_int_to_decimal_ascii_core_tb.sv @@
// Testbench for the signed integer to decimal ASCII text core.
module signed_int_to_decimal_ascii_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sitoa_pkg::CHAR_MINUS;
  import sitoa_pkg::CHAR_ZERO;

  // One value waiting to be offered; hold_for_drain stops it until all text is back.
  typedef struct {
    logic signed [31:0] value;
    bit                 hold_for_drain;
  } value_request_t;

  // One expected character of the decimal text.
  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_character;
  logic               out_last;

  value_request_t pending_values[$];
  text_char_t     expected_text[$];
  int             values_sent = 0;
  int             total_values = 0;
  int             chars_predicted = 0;
  int             chars_checked = 0;
  int             mismatches = 0;
  int             stall_left = 0;
  bit             long_stall_done = 1'b0;

  signed_int_to_decimal_ascii_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Appends the decimal text of one value to the expected characters.
  task automatic predict_text(input logic signed [31:0] value);
    logic [31:0] magnitude;
    logic [7:0]  digit_chars[$];
    text_char_t  entry;
    magnitude = value[31] ? (32'd0 - value) : value;
    do begin
      digit_chars.push_front(CHAR_ZERO + 8'(magnitude % 32'd10));
      magnitude = magnitude / 32'd10;
    end while (magnitude != 32'd0);
    if (value[31]) begin
      entry.character = CHAR_MINUS;
      entry.last      = 1'b0;
      expected_text.push_back(entry);
      chars_predicted++;
    end
    foreach (digit_chars[i]) begin
      entry.character = digit_chars[i];
      entry.last      = (i == digit_chars.size() - 1);
      expected_text.push_back(entry);
      chars_predicted++;
    end
  endtask

  // Request driver: predicts on acceptance, then offers the next value or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(in_value);
        values_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_values.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_values[0].hold_for_drain && chars_checked != chars_predicted) begin
          in_valid <= 1'b0;
        end else if (!(values_sent >= 150 && values_sent < 200) &&
                     $urandom_range(99) < 25) begin
          in_valid <= 1'b0;
        end else begin
          in_value <= pending_values[0].value;
          in_valid <= 1'b1;
          pending_values.pop_front();
        end
      end
    end
  end

  // Result monitor: compares each character with the oldest expectation.
  always @(posedge clk) begin
    text_char_t wanted;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character, expected none, got %0d last %0b",
                   $realtime, out_character, out_last);
          mismatches++;
        end else begin
          wanted = expected_text.pop_front();
          if (out_character !== wanted.character) begin
            $display("%0t: character expected %0d got %0d", $realtime,
                     wanted.character, out_character);
            mismatches++;
          end
          if (out_last !== wanted.last) begin
            $display("%0t: last flag expected %0b got %0b", $realtime,
                     wanted.last, out_last);
            mismatches++;
          end
        end
        chars_checked <= chars_checked + 1;
      end

      // Output readiness: one long hold-off, a window with no idling, else random.
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!long_stall_done && chars_checked >= 100) begin
        long_stall_done = 1'b1;
        stall_left      = 400;
        out_ready       <= 1'b0;
      end else if (chars_checked >= 800 && chars_checked < 1000) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 25);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic signed [31:0] directed_values[] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
      -32'sd100, 32'sd12345, -32'sd54321, 32'sd999999999, 32'sd1000000000,
      -32'sd1000000000, 32'sd1234567890, -32'sd1234567890, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE
    };
    value_request_t     req;
    longint unsigned    span;
    longint unsigned    raw;
    logic [31:0]        magnitude;
    int                 digit_count;

    foreach (directed_values[i]) begin
      req.value          = directed_values[i];
      req.hold_for_drain = 1'b0;
      pending_values.push_back(req);
    end
    // Random part: mostly a random digit count, some fully random words.
    for (int n = 0; n < 290; n++) begin
      if ($urandom_range(4) == 0) begin
        req.value = $urandom;
      end else begin
        digit_count = $urandom_range(1, 10);
        span = 1;
        repeat (digit_count) span = span * 10;
        raw = $urandom;
        magnitude = 32'(raw % span);
        req.value = $urandom_range(1) ? -magnitude : magnitude;
      end
      // The sender pauses for a full drain after the directed part and mid-run.
      req.hold_for_drain = (n == 0 || n == 200);
      pending_values.push_back(req);
    end
    total_values = pending_values.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (values_sent < total_values) @(posedge clk);
    while (chars_checked < chars_predicted) @(posedge clk);
    repeat (64) @(posedge clk);

    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
